/* hw/rtl/msdd_pkg.sv */
// ----------------------------------------------------------------------------
// msdd_pkg: shared types and constants of the MSD / diffusion core
// Sizes, register indexes, request structs and lane/merge control.
// ----------------------------------------------------------------------------
package msdd_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int MAX_ATOMS  = 256;

	localparam int FRAME_AW  = $clog2(MAX_FRAMES);
	localparam int ATOM_AW   = $clog2(MAX_ATOMS);
	localparam int POS_AW    = FRAME_AW + ATOM_AW;
	localparam int POS_DEPTH = MAX_FRAMES * MAX_ATOMS;
	localparam int FC_W      = FRAME_AW + 1;
	localparam int AC_W      = ATOM_AW + 1;
	localparam int CNT_W     = POS_AW;

	localparam int COORD_W = 32;
	localparam int TS_W    = 32;
	localparam int LAG_W   = 6;
	localparam int LT_W    = 38;
	localparam int MSD_W   = 48;
	localparam int ACW_W   = 9;
	localparam int MLAG_W  = ((FC_W > LAG_W) ? FC_W : LAG_W) + 1;

	// squared difference and its accumulation
	localparam int SQ_W   = 2 * COORD_W + 1;
	localparam int SUM3_W = SQ_W + 2;
	localparam int ACC_W  = SQ_W + POS_AW + 2;

	// least-squares fit sums
	localparam int SL_W  = 2 * LAG_W - 1;
	localparam int SL2_W = 3 * LAG_W - 1;
	localparam int SM_W  = MSD_W + LAG_W - 1;
	localparam int PR_W  = MSD_W + LAG_W;
	localparam int SLM_W = MSD_W + 2 * LAG_W - 1;
	localparam int AB_W  = MSD_W + 3 * LAG_W - 2;
	localparam int DEN_W = LAG_W + SL2_W;
	localparam int DTS_W = DEN_W + TS_W;

	// shared divider
	localparam int DVD_W = AB_W + 16;
	localparam int DVS_W = DTS_W + 3;

	// configuration port
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 32;
	localparam logic [CFG_AW-1:0] REG_ATOM_COUNT = 2'd0;
	localparam logic [CFG_AW-1:0] REG_TIME_STEP  = 2'd1;
	localparam logic [CFG_AW-1:0] REG_LAG_LIMIT  = 2'd2;
	localparam logic [ACW_W-1:0]  ATOM_COUNT_RST = 9'd256;
	localparam logic [TS_W-1:0]   TIME_STEP_RST  = 32'd65536;
	localparam logic [LAG_W-1:0]  LAG_LIMIT_RST  = 6'd0;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic                      end_of_trajectory;
	} in_item_t;

	typedef struct packed {
		logic [LAG_W-1:0]        lag_index;
		logic [LT_W-1:0]         lag_time;
		logic [MSD_W-1:0]        msd_value;
		logic signed [MSD_W-1:0] slope_coeff;
		logic                    no_data;
		logic                    last_result;
	} out_item_t;

	typedef struct packed {
		logic clr;
		logic en;
	} merge_ctl_t;

endpackage

/* hw/rtl/msdd_ram.sv */
// ----------------------------------------------------------------------------
// msdd_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module msdd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* hw/rtl/msdd_lane.sv */
// ----------------------------------------------------------------------------
// msdd_lane: one coordinate lane
// Difference of two positions, then its square (two stages).
// ----------------------------------------------------------------------------
module msdd_lane import msdd_pkg::*; (
	input  logic               clk,
	input  logic [COORD_W-1:0] p0,
	input  logic [COORD_W-1:0] p1,
	output logic [SQ_W-1:0]    sq
);

	logic signed [COORD_W:0]     diff_s1;
	logic signed [2*COORD_W+1:0] prod;
	logic [SQ_W-1:0]             sq_s2;

	assign prod = diff_s1 * diff_s1;

	always_ff @(posedge clk) begin
		diff_s1 <= $signed({p1[COORD_W-1], p1}) - $signed({p0[COORD_W-1], p0});
		sq_s2   <= prod[SQ_W-1:0];
	end

	assign sq = sq_s2;

endmodule

/* hw/rtl/msdd_merge.sv */
// ----------------------------------------------------------------------------
// msdd_merge: lane merge
// Adds the three lane squares and accumulates them over one lag.
// ----------------------------------------------------------------------------
module msdd_merge import msdd_pkg::*; (
	input  logic             clk,
	input  merge_ctl_t       ctl,
	input  logic [SQ_W-1:0]  sq_x,
	input  logic [SQ_W-1:0]  sq_y,
	input  logic [SQ_W-1:0]  sq_z,
	output logic [ACC_W-1:0] acc
);

	logic [SUM3_W-1:0] sum_s3;
	logic [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		sum_s3 <= SUM3_W'(sq_x) + SUM3_W'(sq_y) + SUM3_W'(sq_z);
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= acc_q + ACC_W'(sum_s3);
		end
	end

	assign acc = acc_q;

endmodule

/* hw/rtl/msdd_div.sv */
// ----------------------------------------------------------------------------
// msdd_div: sequential divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msdd_div import msdd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CW = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diffv;
	logic             ge;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diffv   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diffv[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/mean_square_displacement_diffusion_core.sv */
// ----------------------------------------------------------------------------
// mean_square_displacement_diffusion_core: trajectory MSD with diffusion fit
// Stores a trajectory, emits MSD per lag and a least-squares diffusion value.
// ----------------------------------------------------------------------------
// Positions stream in one atom per request, one request per cycle, atoms in
// order inside a frame and frames in order; the request that carries
// end_of_trajectory closes the run. Then the core goes busy (in_ready low):
// for each lag L it sweeps (frames - L) * atoms position pairs, one pair per
// cycle, through three coordinate lanes (x, y, z) that read the position
// RAMs on two ports at once; the RAM read, lane and merge registers and the
// shared divider follow, one division per lag. If the largest lag is four or
// more, the fit then walks the upper half of the lags through FIT_RD, FIT_MUL
// and FIT_ACC and takes one more division. Results leave one by one through
// OUT_RD, OUT_LD and an output register; the last result leaves the core
// ready for the next run while it waits to be taken. A run with fewer than
// two frames gives one no_data result. There is no clearing pass after reset.
// Configuration is taken at any cycle but is meant to change only while idle.
// ----------------------------------------------------------------------------
module mean_square_displacement_diffusion_core import msdd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);

	typedef enum logic [16:0] {
		ST_LOAD       = 17'h00001,
		ST_EMPTY      = 17'h00002,
		ST_LAG_INIT   = 17'h00004,
		ST_SWEEP      = 17'h00008,
		ST_DRAIN      = 17'h00010,
		ST_MDIV       = 17'h00020,
		ST_FIT_INIT   = 17'h00040,
		ST_FIT_RD     = 17'h00080,
		ST_FIT_MUL    = 17'h00100,
		ST_FIT_ACC    = 17'h00200,
		ST_FIT_PROD   = 17'h00400,
		ST_FIT_DTS    = 17'h00800,
		ST_FIT_DIV6   = 17'h01000,
		ST_FIT_DSTART = 17'h02000,
		ST_FIT_DWAIT  = 17'h04000,
		ST_OUT_RD     = 17'h08000,
		ST_OUT_LD     = 17'h10000
	} state_t;

	// configuration
	logic [ACW_W-1:0] atom_count_q;
	logic [TS_W-1:0]  time_step_q;
	logic [LAG_W-1:0] lag_limit_q;

	// control
	state_t            state_q;
	logic [FC_W-1:0]   fc_q;
	logic [AC_W-1:0]   ac_q;
	logic [AC_W-1:0]   run_atoms_q;
	logic [FC_W-1:0]   frames_q;
	logic [LAG_W-1:0]  max_lag_q;
	logic [LAG_W-1:0]  lag_q;
	logic [FRAME_AW-1:0] t0_q;
	logic [FRAME_AW-1:0] t0_last_q;
	logic [ATOM_AW-1:0]  atom_q;
	logic [3:0]        pipe_q;
	logic [LAG_W-1:0]  k_q;
	logic              out_valid_q;

	// datapath
	logic [CNT_W-1:0]  count_q;
	logic [LAG_W-1:0]  n_q;
	logic [SL_W-1:0]   s_l_q;
	logic [SL2_W-1:0]  s_l2_q;
	logic [SM_W-1:0]   s_m_q;
	logic [SLM_W-1:0]  s_lm_q;
	logic [PR_W-1:0]   prod_q;
	logic [MSD_W-1:0]  m_q;
	logic [DEN_W-1:0]  den_q;
	logic [AB_W-1:0]   a_q;
	logic [AB_W-1:0]   b_q;
	logic [DTS_W-1:0]  dts_q;
	logic [DVS_W-1:0]  dvs6_q;
	logic [AB_W-1:0]   mag_q;
	logic              neg_q;
	logic [MSD_W-1:0]  coeff_q;
	out_item_t         out_q;

	// load path
	logic              in_fire;
	logic              out_free;
	logic              out_load;
	logic [AC_W-1:0]   clamp_atoms;
	logic [AC_W-1:0]   run_now;
	logic [AC_W-1:0]   ac_inc;
	logic              wrap;
	logic [FC_W-1:0]   fc_next;
	logic              pos_we;
	logic [POS_AW-1:0] pos_waddr;
	logic [MLAG_W-1:0] lim_w;
	logic [MLAG_W-1:0] cap_w;
	logic [LAG_W-1:0]  ml_now;

	// sweep / fit
	logic [POS_AW-1:0] rd_addr0;
	logic [POS_AW-1:0] rd_addr1;
	logic [FRAME_AW-1:0] t1;
	logic              atom_last;
	logic [FC_W+AC_W-1:0] cnt_full;
	logic [LAG_W-1:0]  lagk;
	logic [COORD_W-1:0] px0, py0, pz0, px1, py1, pz1;
	logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
	logic [ACC_W-1:0]  acc;
	merge_ctl_t        mctl;

	// divider
	logic              div_start;
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic              div_done;
	logic [DVD_W-1:0]  div_q;
	logic [MSD_W-1:0]  msd_sat;
	logic [MSD_W-1:0]  coeff_sat;

	// MSD store
	logic              msd_we;
	logic [FRAME_AW-1:0] msd_waddr;
	logic [FRAME_AW-1:0] msd_raddr_fit;
	logic [FRAME_AW-1:0] msd_raddr_out;
	logic [MSD_W-1:0]  msd_rd_fit;
	logic [MSD_W-1:0]  msd_rd_out;

	assign in_ready = (state_q == ST_LOAD);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && (state_q == ST_EMPTY || state_q == ST_OUT_LD);

	// atoms per frame are latched on the first request of a run
	always_comb begin
		if (atom_count_q == '0) begin
			clamp_atoms = AC_W'(1);
		end else if (32'(atom_count_q) > 32'(MAX_ATOMS)) begin
			clamp_atoms = AC_W'(MAX_ATOMS);
		end else begin
			clamp_atoms = AC_W'(atom_count_q);
		end
	end

	assign run_now = (fc_q == '0 && ac_q == '0) ? clamp_atoms : run_atoms_q;
	assign ac_inc  = ac_q + 1'b1;
	assign wrap    = ac_inc >= run_now;
	assign fc_next = (wrap && 32'(fc_q) < 32'(MAX_FRAMES)) ? fc_q + 1'b1 : fc_q;
	assign pos_we  = in_fire && 32'(fc_q) < 32'(MAX_FRAMES) && ac_q < run_now;
	assign pos_waddr = {fc_q[FRAME_AW-1:0], ac_q[ATOM_AW-1:0]};

	// largest lag: limit, or half the frames, never past frames - 1
	assign lim_w  = (lag_limit_q == '0) ? MLAG_W'(fc_next >> 1) : MLAG_W'(lag_limit_q);
	assign cap_w  = MLAG_W'(fc_next) - 1'b1;
	assign ml_now = (lim_w > cap_w) ? cap_w[LAG_W-1:0] : lim_w[LAG_W-1:0];

	// sweep addressing
	assign t1        = FRAME_AW'(MLAG_W'(t0_q) + MLAG_W'(lag_q));
	assign rd_addr0  = {t0_q, atom_q};
	assign rd_addr1  = {t1, atom_q};
	assign atom_last = (AC_W'(atom_q) == run_atoms_q - 1'b1);
	assign cnt_full  = (FC_W+AC_W)'(frames_q - FC_W'(lag_q)) * (FC_W+AC_W)'(run_atoms_q);
	assign lagk      = k_q + 1'b1;

	assign mctl.clr = (state_q == ST_LAG_INIT);
	assign mctl.en  = pipe_q[3];

	// divider operands
	assign div_start = (state_q == ST_DRAIN && pipe_q == '0) ||
		(state_q == ST_FIT_DSTART && dvs6_q != '0);
	assign div_dvd = (state_q == ST_FIT_DSTART) ? {mag_q, 16'h0000} : DVD_W'(acc >> 16);
	assign div_dvs = (state_q == ST_FIT_DSTART) ? dvs6_q : DVS_W'(count_q);

	assign msd_sat = (|div_q[DVD_W-1:MSD_W]) ? '1 : div_q[MSD_W-1:0];

	// slope magnitude to signed Q32.16 with saturation
	always_comb begin
		if (neg_q) begin
			if ((|div_q[DVD_W-1:MSD_W]) || (div_q[MSD_W-1] && (|div_q[MSD_W-2:0]))) begin
				coeff_sat = {1'b1, {(MSD_W-1){1'b0}}};
			end else begin
				coeff_sat = -div_q[MSD_W-1:0];
			end
		end else begin
			if (|div_q[DVD_W-1:MSD_W-1]) begin
				coeff_sat = {1'b0, {(MSD_W-1){1'b1}}};
			end else begin
				coeff_sat = div_q[MSD_W-1:0];
			end
		end
	end

	assign msd_we        = (state_q == ST_MDIV) && div_done;
	assign msd_waddr     = FRAME_AW'(lag_q - 1'b1);
	assign msd_raddr_fit = FRAME_AW'(k_q);
	assign msd_raddr_out = FRAME_AW'(lag_q - 1'b1);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q <= ATOM_COUNT_RST;
			time_step_q  <= TIME_STEP_RST;
			lag_limit_q  <= LAG_LIMIT_RST;
			state_q      <= ST_LOAD;
			fc_q         <= '0;
			ac_q         <= '0;
			run_atoms_q  <= AC_W'(1);
			frames_q     <= '0;
			max_lag_q    <= '0;
			lag_q        <= '0;
			t0_q         <= '0;
			t0_last_q    <= '0;
			atom_q       <= '0;
			pipe_q       <= '0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_ATOM_COUNT: atom_count_q <= cfg_wdata[ACW_W-1:0];
					REG_TIME_STEP:  time_step_q  <= cfg_wdata[TS_W-1:0];
					REG_LAG_LIMIT:  lag_limit_q  <= cfg_wdata[LAG_W-1:0];
					default: ;
				endcase
			end

			pipe_q      <= {pipe_q[2:0], state_q == ST_SWEEP};
			// a loaded result stays until taken
			out_valid_q <= out_load || (out_valid_q && !out_ready);

			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						run_atoms_q <= run_now;
						if (in_data.end_of_trajectory) begin
							fc_q      <= '0;
							ac_q      <= '0;
							frames_q  <= fc_next;
							max_lag_q <= ml_now;
							lag_q     <= LAG_W'(1);
							state_q   <= (32'(fc_next) < 32'd2) ? ST_EMPTY : ST_LAG_INIT;
						end else begin
							fc_q <= fc_next;
							ac_q <= wrap ? '0 : ac_inc;
						end
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LAG_INIT: begin
					t0_q      <= '0;
					atom_q    <= '0;
					t0_last_q <= FRAME_AW'(frames_q - FC_W'(lag_q) - 1'b1);
					state_q   <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (atom_last) begin
						atom_q <= '0;
						if (t0_q == t0_last_q) begin
							state_q <= ST_DRAIN;
						end else begin
							t0_q <= t0_q + 1'b1;
						end
					end else begin
						atom_q <= atom_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (pipe_q == '0) begin
						state_q <= ST_MDIV;
					end
				end
				ST_MDIV: begin
					if (div_done) begin
						if (lag_q == max_lag_q) begin
							state_q <= ST_FIT_INIT;
						end else begin
							lag_q   <= lag_q + 1'b1;
							state_q <= ST_LAG_INIT;
						end
					end
				end
				ST_FIT_INIT: begin
					lag_q <= LAG_W'(1);
					k_q   <= max_lag_q >> 1;
					state_q <= (max_lag_q < LAG_W'(4)) ? ST_OUT_RD : ST_FIT_RD;
				end
				ST_FIT_RD:   state_q <= ST_FIT_MUL;
				ST_FIT_MUL:  state_q <= ST_FIT_ACC;
				ST_FIT_ACC: begin
					if (lagk == max_lag_q) begin
						state_q <= ST_FIT_PROD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_FIT_RD;
					end
				end
				ST_FIT_PROD: state_q <= ST_FIT_DTS;
				ST_FIT_DTS:  state_q <= ST_FIT_DIV6;
				ST_FIT_DIV6: state_q <= ST_FIT_DSTART;
				ST_FIT_DSTART: begin
					state_q <= (dvs6_q == '0) ? ST_OUT_RD : ST_FIT_DWAIT;
				end
				ST_FIT_DWAIT: begin
					if (div_done) begin
						state_q <= ST_OUT_RD;
					end
				end
				ST_OUT_RD:   state_q <= ST_OUT_LD;
				ST_OUT_LD: begin
					if (out_free) begin
						if (lag_q == max_lag_q) begin
							state_q <= ST_LOAD;
						end else begin
							lag_q   <= lag_q + 1'b1;
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_EMPTY: begin
				if (out_free) begin
					// all fields zero but no_data and last_result
					out_q <= {{(LAG_W + LT_W + 2 * MSD_W){1'b0}}, 2'b11};
				end
			end
			ST_LAG_INIT: begin
				count_q <= cnt_full[CNT_W-1:0];
			end
			ST_FIT_INIT: begin
				coeff_q <= '0;
				n_q     <= max_lag_q - (max_lag_q >> 1);
				s_l_q   <= '0;
				s_l2_q  <= '0;
				s_m_q   <= '0;
				s_lm_q  <= '0;
			end
			ST_FIT_MUL: begin
				prod_q <= PR_W'(lagk) * PR_W'(msd_rd_fit);
				m_q    <= msd_rd_fit;
			end
			ST_FIT_ACC: begin
				s_l_q  <= s_l_q + SL_W'(lagk);
				s_l2_q <= s_l2_q + SL2_W'((2*LAG_W)'(lagk) * (2*LAG_W)'(lagk));
				s_m_q  <= s_m_q + SM_W'(m_q);
				s_lm_q <= s_lm_q + SLM_W'(prod_q);
			end
			ST_FIT_PROD: begin
				den_q <= DEN_W'(n_q) * DEN_W'(s_l2_q) - DEN_W'(s_l_q) * DEN_W'(s_l_q);
				a_q   <= AB_W'(n_q) * AB_W'(s_lm_q);
				b_q   <= AB_W'(s_l_q) * AB_W'(s_m_q);
			end
			ST_FIT_DTS: begin
				dts_q <= DTS_W'(den_q) * DTS_W'(time_step_q);
				neg_q <= a_q < b_q;
				mag_q <= (a_q < b_q) ? b_q - a_q : a_q - b_q;
			end
			ST_FIT_DIV6: begin
				dvs6_q <= (DVS_W'(dts_q) << 2) + (DVS_W'(dts_q) << 1);
			end
			ST_FIT_DWAIT: begin
				if (div_done) begin
					coeff_q <= coeff_sat;
				end
			end
			ST_OUT_LD: begin
				if (out_free) begin
					out_q.lag_index   <= lag_q;
					out_q.lag_time    <= LT_W'(lag_q) * LT_W'(time_step_q);
					out_q.msd_value   <= msd_rd_out;
					out_q.slope_coeff <= (lag_q == max_lag_q) ? coeff_q : '0;
					out_q.no_data     <= 1'b0;
					out_q.last_result <= (lag_q == max_lag_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// trajectory store, one RAM per coordinate
	msdd_ram #(.WIDTH(COORD_W), .DEPTH(POS_DEPTH)) u_ram_x (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(in_data.coord_x),
		.raddr_a(rd_addr0), .rdata_a(px0), .raddr_b(rd_addr1), .rdata_b(px1)
	);
	msdd_ram #(.WIDTH(COORD_W), .DEPTH(POS_DEPTH)) u_ram_y (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(in_data.coord_y),
		.raddr_a(rd_addr0), .rdata_a(py0), .raddr_b(rd_addr1), .rdata_b(py1)
	);
	msdd_ram #(.WIDTH(COORD_W), .DEPTH(POS_DEPTH)) u_ram_z (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(in_data.coord_z),
		.raddr_a(rd_addr0), .rdata_a(pz0), .raddr_b(rd_addr1), .rdata_b(pz1)
	);

	msdd_lane u_lane_x (.clk(clk), .p0(px0), .p1(px1), .sq(sq_x));
	msdd_lane u_lane_y (.clk(clk), .p0(py0), .p1(py1), .sq(sq_y));
	msdd_lane u_lane_z (.clk(clk), .p0(pz0), .p1(pz1), .sq(sq_z));

	msdd_merge u_merge (
		.clk(clk), .ctl(mctl), .sq_x(sq_x), .sq_y(sq_y), .sq_z(sq_z), .acc(acc)
	);

	msdd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .done(div_done), .quotient(div_q)
	);

	// per-lag MSD store: port a feeds the fit, port b the results
	msdd_ram #(.WIDTH(MSD_W), .DEPTH(MAX_FRAMES)) u_msd_ram (
		.clk(clk), .we(msd_we), .waddr(msd_waddr), .wdata(msd_sat),
		.raddr_a(msd_raddr_fit), .rdata_a(msd_rd_fit),
		.raddr_b(msd_raddr_out), .rdata_b(msd_rd_out)
	);

endmodule

/* hw/rtl/msdd_checker.sv */
// ----------------------------------------------------------------------------
// msdd_checker: port-level checks of the MSD / diffusion core
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module msdd_checker import msdd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input in_item_t          in_data,
	input logic              out_valid,
	input logic              out_ready,
	input out_item_t         out_data
);

	// a stalled result request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result request changed while stalled");

	// a waiting position request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("position request changed while waiting");

	// the empty result is the last of its run and has zero lag index and MSD
	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_data |->
			out_data.last_result && out_data.lag_index == '0 && out_data.msd_value == '0)
		else $error("empty result malformed");

	// the coefficient shows only on the last result
	a_coeff_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_result |-> out_data.slope_coeff == '0)
		else $error("coefficient on a non-final result");

	// no new trajectory while a run is still being reported
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_result |-> !in_ready)
		else $error("input taken while a run is still reporting");

endmodule

bind mean_square_displacement_diffusion_core msdd_checker u_msdd_checker (.*);

/* tb/mean_square_displacement_diffusion_core_tb.sv */
// ----------------------------------------------------------------------------
// mean_square_displacement_diffusion_core_tb: self-checking bench of the core
// Streams trajectories in, predicts per-lag MSD and the fitted diffusion
// value in-bench, and checks every result in order under random stalls.
// ----------------------------------------------------------------------------
module mean_square_displacement_diffusion_core_tb;
	import msdd_pkg::*;

	localparam int WATCHDOG_LIMIT = 300000;
	localparam int DRAIN_CYCLES   = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = REG_ATOM_COUNT;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	always #2 clk = ~clk;

	mean_square_displacement_diffusion_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	// shadow of the core: configuration, counters and stores
	logic [ACW_W-1:0] sh_atom_count = ATOM_COUNT_RST;
	logic [TS_W-1:0]  sh_time_step  = TIME_STEP_RST;
	logic [LAG_W-1:0] sh_lag_limit  = LAG_LIMIT_RST;
	int unsigned frame_cnt = 0, atom_cnt = 0, run_atoms = 1;
	logic [31:0] traj_pos [0:MAX_FRAMES*MAX_ATOMS*3-1];
	logic [47:0] lag_msd [0:MAX_FRAMES-1];

	out_item_t lag_results_q[$];

	bit quiet = 1'b0;
	bit in_fire = 1'b0;
	int mismatches = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int runs_done = 0;
	int idle_cycles = 0;

	// mean of |r(t0+lag) - r(t0)|^2 over origins and atoms, Q32.16 saturating
	function automatic logic [47:0] lag_mean_sq(int unsigned frames, int unsigned lag,
			int unsigned na);
		logic [127:0] sum;
		logic [127:0] dvs;
		logic [127:0] q;
		longint d;
		logic [63:0] u;
		int unsigned i0, i1;
		sum = '0;
		for (int unsigned t0 = 0; t0 + lag < frames; t0++)
			for (int unsigned a = 0; a < na; a++)
				for (int c = 0; c < 3; c++) begin
					i0 = ((t0 * MAX_ATOMS) + a) * 3 + c;
					i1 = (((t0 + lag) * MAX_ATOMS) + a) * 3 + c;
					d = longint'($signed(traj_pos[i1])) - longint'($signed(traj_pos[i0]));
					u = (d < 0) ? 64'(-d) : 64'(d);
					sum = sum + {64'd0, u} * {64'd0, u};
				end
		dvs = {64'd0, 64'((frames - lag) * na)} << 16;
		q = sum / dvs;
		return (q > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q[47:0];
	endfunction

	// least-squares slope over the upper half of the lags, over six
	function automatic logic [47:0] diffusion_fit(int unsigned max_lag);
		int unsigned start;
		logic [63:0] n, s_l, s_l2, s_m, s_lm, den, dvs, lag;
		logic [127:0] a, b, mag, q;
		bit neg;
		if (max_lag < 4)
			return '0;
		start = max_lag / 2;
		n = max_lag - start;
		s_l = 0; s_l2 = 0; s_m = 0; s_lm = 0;
		for (int unsigned k = start; k < max_lag; k++) begin
			lag = k + 1;
			s_l += lag;
			s_l2 += lag * lag;
			s_m += lag_msd[k];
			s_lm += lag * lag_msd[k];
		end
		den = n * s_l2 - s_l * s_l;
		dvs = den * {32'd0, sh_time_step} * 64'd6;
		if (dvs == 0)
			return '0;
		a = {64'd0, n} * {64'd0, s_lm};
		b = {64'd0, s_l} * {64'd0, s_m};
		neg = a < b;
		mag = neg ? b - a : a - b;
		q = (mag << 16) / {64'd0, dvs};
		if (neg)
			return (q > (128'd1 << 47)) ? 48'h8000_0000_0000 : 48'(-q[47:0]);
		return (q > ((128'd1 << 47) - 1)) ? 48'h7FFF_FFFF_FFFF : q[47:0];
	endfunction

	// shadow step for one accepted position request
	task automatic absorb_position(in_item_t it);
		int unsigned frames, max_lag;
		logic [47:0] coeff;
		out_item_t r;
		int unsigned base;
		if (frame_cnt == 0 && atom_cnt == 0) begin
			run_atoms = (sh_atom_count == 0) ? 1 : sh_atom_count;
			if (run_atoms > MAX_ATOMS)
				run_atoms = MAX_ATOMS;
		end
		if (frame_cnt < MAX_FRAMES && atom_cnt < run_atoms) begin
			base = ((frame_cnt * MAX_ATOMS) + atom_cnt) * 3;
			traj_pos[base]     = it.coord_x;
			traj_pos[base + 1] = it.coord_y;
			traj_pos[base + 2] = it.coord_z;
		end
		atom_cnt++;
		if (atom_cnt >= run_atoms) begin
			atom_cnt = 0;
			if (frame_cnt < MAX_FRAMES)
				frame_cnt++;
		end
		if (!it.end_of_trajectory)
			return;
		frames = frame_cnt;
		frame_cnt = 0;
		atom_cnt = 0;
		runs_done++;
		if (frames < 2) begin
			r = '0;
			r.no_data = 1'b1;
			r.last_result = 1'b1;
			lag_results_q.insert(lag_results_q.size(), r);
			return;
		end
		max_lag = (sh_lag_limit == 0) ? frames / 2 : sh_lag_limit;
		if (max_lag > frames - 1)
			max_lag = frames - 1;
		for (int unsigned l = 1; l <= max_lag; l++)
			lag_msd[l - 1] = lag_mean_sq(frames, l, run_atoms);
		coeff = diffusion_fit(max_lag);
		for (int unsigned l = 1; l <= max_lag; l++) begin
			r = '0;
			r.lag_index = LAG_W'(l);
			r.lag_time = LT_W'(64'(l) * 64'(sh_time_step));
			r.msd_value = lag_msd[l - 1];
			r.slope_coeff = (l == max_lag) ? coeff : '0;
			r.last_result = (l == max_lag);
			lag_results_q.insert(lag_results_q.size(), r);
		end
	endtask

	// posedge monitor: accept requests into the shadow, check results, watchdog
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			absorb_position(in_data);
			requests_sent++;
		end
		if (out_valid && out_ready) begin
			results_seen++;
			if (lag_results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR unexpected result %p", out_data);
			end else begin
				if (out_data !== lag_results_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR result mismatch\n  exp %p\n  got %p",
							lag_results_q[0], out_data);
				end
				void'(lag_results_q.pop_front());
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR watchdog: no request moved for %0d cycles", idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// receiver stalls in random bursts, none once quiet
	int stall_left = 0;
	always @(negedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= (stall_left == 0);
		end else if ($urandom_range(3) == 0) begin
			stall_left = $urandom_range(1, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ATOM_COUNT: sh_atom_count = val[ACW_W-1:0];
			REG_TIME_STEP:  sh_time_step = val[TS_W-1:0];
			REG_LAG_LIMIT:  sh_lag_limit = val[LAG_W-1:0];
			default: ;
		endcase
	endtask

	// send one position request; returns at the negedge after acceptance
	task automatic send_position(in_item_t it);
		int gap;
		if (!quiet && $urandom_range(4) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(negedge clk); while (!in_fire);
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'hFFFFF)) - 32'sh80000);
			default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		endcase
	endfunction

	// one run: nframes whole frames plus extra atoms, end mark on the last
	task automatic send_run(int atoms, int nframes, int extra, int mode);
		in_item_t it;
		int total;
		total = atoms * nframes + extra;
		for (int i = 0; i < total; i++) begin
			it.coord_x = rand_coord(mode);
			it.coord_y = rand_coord(mode);
			it.coord_z = rand_coord(mode);
			it.end_of_trajectory = (i == total - 1);
			send_position(it);
		end
		release_input();
	endtask

	task automatic wait_drained();
		while (lag_results_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic test_no_data();
		write_reg(REG_ATOM_COUNT, 3);
		send_run(3, 0, 1, 1);           // lone atom, no whole frame
		wait_drained();
		send_run(3, 1, 2, 0);           // one frame plus a dropped partial one
		wait_drained();
	endtask

	task automatic test_extremes();
		write_reg(REG_ATOM_COUNT, 1);
		write_reg(REG_LAG_LIMIT, 0);
		write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
		send_run(1, 9, 0, 2);           // rails: saturating msd and slope
		wait_drained();
		write_reg(REG_TIME_STEP, 0);    // zero denominator
		send_run(1, 8, 0, 1);
		wait_drained();
		write_reg(REG_TIME_STEP, 1);
		write_reg(REG_LAG_LIMIT, 3);    // short fit
		send_run(1, 6, 0, 0);
		wait_drained();
		write_reg(REG_ATOM_COUNT, 0);   // counts as one atom
		write_reg(REG_LAG_LIMIT, 1);
		send_run(1, 3, 0, 0);
		wait_drained();
	endtask

	task automatic test_capacity();
		write_reg(REG_ATOM_COUNT, 1);
		write_reg(REG_LAG_LIMIT, 63);
		write_reg(REG_TIME_STEP, 65536);
		send_run(1, 65, 0, 1);          // frames beyond the store are ignored
		wait_drained();
	endtask

	task automatic test_random_runs();
		int budget, atoms, nfr, extra, mode;
		budget = 14;
		while (budget > 0) begin
			if (budget < 25)
				quiet = 1'b1;
			atoms = $urandom_range(1, 4);
			nfr = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 10);
			while (nfr > 2 && atoms * nfr > budget)
				nfr--;
			extra = $urandom_range(0, 3) == 0 ? $urandom_range(1, atoms) : 0;
			if (extra == atoms)
				extra = 0;
			if (atoms * nfr + extra == 0)
				extra = 1;
			mode = $urandom_range(0, 5) == 0 ? 0 : 1;
			write_reg(REG_ATOM_COUNT, atoms);
			write_reg(REG_TIME_STEP, $urandom_range(0, 3) == 0 ? $urandom() :
				$urandom_range(1, 32'h40000));
			write_reg(REG_LAG_LIMIT, $urandom_range(0, 2) == 0 ? $urandom_range(0, 63) :
				$urandom_range(0, 6));
			send_run(atoms, nfr, extra, mode);
			budget -= atoms * nfr + extra;
			wait_drained();
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_no_data();
		test_extremes();
		test_capacity();
		test_random_runs();
		wait_drained();
		$display("Covered %0d runs, %0d position requests, %0d lag results checked.",
			runs_done, requests_sent, results_seen);
		$display("Mismatches: %0d, results left waiting: %0d",
			mismatches, lag_results_q.size());
		if (mismatches == 0 && lag_results_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
